[hw/rtl/wamm_pkg.sv]
// Package for the windowed average / min / max unit.
// Holds the window size, derived widths, 32-bit limits and the divider request type.
// Used by wamm_div, windowed_average_min_max_unit and the testbench; depends on nothing.
`timescale 1ns / 1ps

package wamm_pkg;

  localparam int WINDOW_LEN = 16;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W      = DATA_W + $clog2(WINDOW_LEN) + 1;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int OUT_CNT_W  = 5;

  localparam logic signed [DATA_W-1:0] SAMPLE_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MARKER_RESET = SAMPLE_MIN;

  // Request to the serial divider: magnitude of the sum, the count and the sign
  typedef struct packed {
    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

[hw/rtl/wamm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module wamm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/wamm_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, sign applied at the end.
// Depends on wamm_pkg.
`timescale 1ns / 1ps

module wamm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  wamm_pkg::div_req_t             req,
  output logic                           done,
  output logic signed [wamm_pkg::DATA_W-1:0] quot
);

  import wamm_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  dq;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic              neg;

  logic [CNT_W:0]    rem_shift;
  logic              q_bit;
  logic [CNT_W:0]    rem_diff;
  logic [SUM_W-1:0]  q_full;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_shift = {rem, dq[SUM_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    q_bit     = (rem_shift >= {1'b0, divisor});
  end

  // Control: run SUM_W steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      dq      <= req.mag;
      rem     <= '0;
      divisor <= req.divisor;
      neg     <= req.neg;
    end else if (busy) begin
      dq  <= {dq[SUM_W-2:0], q_bit};
      rem <= q_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    end
  end

  // Apply sign; the magnitude always fits the 32-bit result
  always_comb begin
    q_full = neg ? (~dq + 1'b1) : dq;
    quot   = q_full[DATA_W-1:0];
  end

endmodule

[hw/rtl/windowed_average_min_max_unit.sv]
// Windowed average / min / max: ring window of WINDOW_LEN samples, one transaction at a time.
// Each input starts a scan of the window RAM, one slot per cycle, then the divider forms
// the mean one quotient bit per cycle; an empty window skips the divider. Input stalls until
// the result is in the output register, and stays stalled while the output stalls.
// Synchronous reset clears the valid bits, zeroes the write position, marker -2147483648.
`timescale 1ns / 1ps

module windowed_average_min_max_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic signed [wamm_pkg::DATA_W-1:0]     cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [wamm_pkg::DATA_W-1:0]     sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [wamm_pkg::DATA_W-1:0]     mean_value,
  output logic signed [wamm_pkg::DATA_W-1:0]     min_value,
  output logic signed [wamm_pkg::DATA_W-1:0]     max_value,
  output logic signed [wamm_pkg::DATA_W-1:0]     last_value,
  output logic [wamm_pkg::OUT_CNT_W-1:0]         valid_count
);

  import wamm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]               state;
  logic [IDX_W-1:0]         wpos;
  logic [WINDOW_LEN-1:0]    slot_valid;
  logic signed [DATA_W-1:0] empty_marker;
  logic signed [DATA_W-1:0] latest;

  logic [CNT_W-1:0]         scan_cnt;
  logic                     rd_pend;
  logic                     rd_slot_valid;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] scan_v;

  logic signed [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] lo;
  logic signed [DATA_W-1:0] hi;
  logic signed [DATA_W-1:0] mean_hold;

  logic                     in_accept;
  logic                     scan_last;
  logic                     out_load;
  logic                     div_start;
  logic                     div_done;
  div_req_t                 div_req;
  logic signed [DATA_W-1:0] div_quot;

  assign in_stall  = rst || (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign scan_last = (state == ST_SCAN) && (scan_cnt == CNT_W'(WINDOW_LEN)) && !rd_pend;
  assign div_start = scan_last && (count != '0);
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  // Window storage
  wamm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (in_accept),
    .waddr (wpos),
    .wdata (sample),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Serial divider for the mean
  always_comb begin
    div_req.neg     = sum[SUM_W-1];
    div_req.mag     = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    div_req.divisor = count;
  end

  wamm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // A slot never written reads as the reset marker
  assign scan_v = rd_slot_valid ? $signed(rd_data) : MARKER_RESET;

  // Marker register
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_marker <= MARKER_RESET;
    end else if (cfg_wr_en) begin
      empty_marker <= cfg_wr_data;
    end
  end

  // Slot valid bits and write position
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      wpos       <= '0;
    end else if (in_accept) begin
      slot_valid[wpos] <= 1'b1;
      wpos <= (wpos == IDX_W'(WINDOW_LEN - 1)) ? '0 : wpos + 1'b1;
    end
  end

  // Output valid: set on load, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
            rd_pend  <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_cnt != CNT_W'(WINDOW_LEN)) begin
            scan_cnt <= scan_cnt + 1'b1;
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (scan_last) begin
            state <= (count != '0) ? ST_DIV : ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Scan datapath: accumulate sum, count, min and max of non-marker slots; hold latest sample and mean
  always_ff @(posedge clk) begin
    rd_slot_valid <= slot_valid[scan_cnt[IDX_W-1:0]];
    if (in_accept) begin
      latest <= sample;
      sum    <= '0;
      count  <= '0;
      lo     <= SAMPLE_MAX;
      hi     <= SAMPLE_MIN;
    end else if (state == ST_SCAN && rd_pend && scan_v != empty_marker) begin
      sum   <= sum + {{(SUM_W - DATA_W){scan_v[DATA_W-1]}}, scan_v};
      count <= count + 1'b1;
      if (scan_v < lo) begin
        lo <= scan_v;
      end
      if (scan_v > hi) begin
        hi <= scan_v;
      end
    end
    if (scan_last && count == '0) begin
      mean_hold <= empty_marker;
    end else if (div_done) begin
      mean_hold <= div_quot;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_value  <= mean_hold;
      min_value   <= lo;
      max_value   <= hi;
      last_value  <= latest;
      valid_count <= OUT_CNT_W'(count);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count <= CNT_W'(WINDOW_LEN)))
    else $error("valid count beyond window length");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (div_req.divisor != '0))
    else $error("divider started with zero count");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && count != '0) |-> (lo <= hi))
    else $error("minimum above maximum with non-empty window");

  a_scan_idle_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && rd_pend) |=> (state == ST_SCAN || state == ST_DIV || state == ST_OUT))
    else $error("scan left for idle before result");

endmodule

[test/windowed_average_min_max_unit_test.sv]
// Self-checking testbench for windowed_average_min_max_unit: drives samples and marker
// writes, predicts mean / min / max / last / count per transaction and checks every result.
// Depends on wamm_pkg and windowed_average_min_max_unit.
`timescale 1ns / 1ps

module windowed_average_min_max_unit_test;
  import wamm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = WINDOW_LEN + SUM_W + 10;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic signed [DATA_W-1:0] mean_v;
    logic signed [DATA_W-1:0] min_v;
    logic signed [DATA_W-1:0] max_v;
    logic signed [DATA_W-1:0] last_v;
    logic [OUT_CNT_W-1:0]     count_v;
  } window_stats_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic signed [DATA_W-1:0] cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] mean_value;
  logic signed [DATA_W-1:0] min_value;
  logic signed [DATA_W-1:0] max_value;
  logic signed [DATA_W-1:0] last_value;
  logic [OUT_CNT_W-1:0]     valid_count;

  // Predictor copy of the window, its write pointer and the marker register
  logic signed [DATA_W-1:0] win_slots [WINDOW_LEN];
  int unsigned              wr_pos = 0;
  logic signed [DATA_W-1:0] marker_reg = MARKER_RESET;
  window_stats_t            expected_stats [$];

  // Traffic shaping
  bit          sender_gaps = 1'b0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_phase = 0;

  int cycle_count = 0;
  int fail_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int marker_writes = 0;

  windowed_average_min_max_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mean_value  (mean_value),
    .min_value   (min_value),
    .max_value   (max_value),
    .last_value  (last_value),
    .valid_count (valid_count)
  );

  always #1 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("windowed_average_min_max_unit: mismatch");
      $finish;
    end
  end

  // Receiver stall pattern, with a long hold-off whenever one is requested
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 9) < 3);
        STALL_PERIODIC: out_stall <= ((stall_phase % 7) < 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Write one sample into the predicted window and work out the statistics
  function automatic window_stats_t push_window_sample(input logic signed [DATA_W-1:0] s);
    window_stats_t r;
    longint        total;
    longint        n;
    total = 0;
    n = 0;
    win_slots[wr_pos] = s;
    wr_pos = (wr_pos + 1) % WINDOW_LEN;
    r.min_v = SAMPLE_MAX;
    r.max_v = SAMPLE_MIN;
    r.last_v = s;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (win_slots[i] != marker_reg) begin
        total += longint'(win_slots[i]);
        n++;
        if (win_slots[i] < r.min_v) r.min_v = win_slots[i];
        if (win_slots[i] > r.max_v) r.max_v = win_slots[i];
      end
    end
    // Division of signed longints truncates toward zero
    if (n != 0) begin
      r.mean_v = DATA_W'(total / n);
    end else begin
      r.mean_v = marker_reg;
    end
    r.count_v = OUT_CNT_W'(n);
    return r;
  endfunction

  // Compare each output transaction with the oldest prediction
  always @(negedge clk) begin
    window_stats_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $error("Result with no sample outstanding: mean %0d", mean_value);
        fail_count++;
      end else begin
        e = expected_stats.pop_front();
        results_checked++;
        if (mean_value !== e.mean_v) begin
          $error("mean_value: expected %0d, got %0d", e.mean_v, mean_value);
          fail_count++;
        end
        if (min_value !== e.min_v) begin
          $error("min_value: expected %0d, got %0d", e.min_v, min_value);
          fail_count++;
        end
        if (max_value !== e.max_v) begin
          $error("max_value: expected %0d, got %0d", e.max_v, max_value);
          fail_count++;
        end
        if (last_value !== e.last_v) begin
          $error("last_value: expected %0d, got %0d", e.last_v, last_value);
          fail_count++;
        end
        if (valid_count !== e.count_v) begin
          $error("valid_count: expected %0d, got %0d", e.count_v, valid_count);
          fail_count++;
        end
      end
    end
  end

  // Offer one sample and hold it until the input transaction completes
  task automatic send_sample(input logic signed [DATA_W-1:0] s);
    int  gap;
    bit  taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    expected_stats.push_back(push_window_sample(s));
    samples_sent++;
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write the marker register while the block is idle
  task automatic set_marker(input logic signed [DATA_W-1:0] m);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    marker_reg = m;
    marker_writes++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1: return marker_reg;
      2: begin
        case ($urandom_range(0, 4))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return SAMPLE_MIN + 1;
          3:       return -1;
          default: return 0;
        endcase
      end
      3: return $signed(DATA_W'($urandom_range(0, 200))) - 100;
      default: return $signed($urandom());
    endcase
  endfunction

  // Sample equal to the reset marker on a fresh window: no valid entries
  task automatic test_empty_window();
    send_sample(SAMPLE_MIN);
  endtask

  // Extremes of the sample field, negative truncation and exact sums
  task automatic test_field_extremes();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN + 1);
    send_sample(-1);
    send_sample(-2);
    send_sample(0);
    send_sample(1);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
  endtask

  // Change the marker with never-written slots still at the reset value
  task automatic test_marker_changes();
    set_marker(0);
    send_sample(0);
    send_sample(7);
    set_marker(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(-7);
  endtask

  // Wrap the ring so that old entries get overwritten
  task automatic test_window_wrap();
    set_marker(MARKER_RESET);
    for (int i = 0; i < 10; i++) send_sample(SAMPLE_MAX - i);
  endtask

  // Hold the output off for a long stretch while the sender keeps offering samples
  task automatic test_output_holdoff();
    wait_idle();
    sender_gaps = 1'b0;
    stall_mode = STALL_NONE;
    hold_seq++;
    for (int i = 0; i < 8; i++) send_sample(pick_sample());
  endtask

  // Random samples over several marker settings and traffic patterns
  task automatic test_random_traffic();
    logic signed [DATA_W-1:0] markers [5];
    markers[0] = SAMPLE_MAX;
    markers[1] = 0;
    markers[2] = $signed($urandom());
    markers[3] = -1;
    markers[4] = SAMPLE_MIN;
    foreach (markers[p]) begin
      set_marker(markers[p]);
      for (int i = 0; i < 80; i++) begin
        if (i % 20 == 0) begin
          sender_gaps = ($urandom_range(0, 2) != 0);
          stall_mode = stall_mode_t'($urandom_range(0, 2));
        end
        send_sample(pick_sample());
      end
    end
  endtask

  initial begin
    foreach (win_slots[i]) win_slots[i] = MARKER_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_window();
    test_field_extremes();
    test_marker_changes();
    test_window_wrap();
    test_output_holdoff();
    test_random_traffic();

    // Drain, then watch for stray results
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_stats.size() != 0) begin
      $error("%0d results never arrived", expected_stats.size());
      fail_count++;
    end

    $display("Sent %0d samples and checked %0d results across %0d marker settings,",
             samples_sent, results_checked, marker_writes);
    $display("covering field extremes, marker-valued samples, ring wrap and a long hold-off.");
    if (fail_count == 0) begin
      $display("windowed_average_min_max_unit: match");
    end else begin
      $display("windowed_average_min_max_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/wamm_pkg.sv
hw/rtl/wamm_ram.sv
hw/rtl/wamm_div.sv
hw/rtl/windowed_average_min_max_unit.sv
test/windowed_average_min_max_unit_test.sv
